// ===== hdl/pls_pkg.sv =====
// Shared types, constants and codes of the priority LED sequencer.
package pls_pkg;

   localparam int LED_COUNT_DEFAULT = 8;
   localparam int NUM_SEQ           = 3;
   localparam int WALK_LIMIT        = 16;
   localparam int CSR_ADDR_W        = 5;

   localparam logic [1:0] SEQ_CALIB     = 2'd0;
   localparam logic [1:0] SEQ_HEARTBEAT = 2'd1;
   localparam logic [1:0] SEQ_LINK      = 2'd2;
   localparam logic [1:0] SEQ_NONE      = 2'd3;

   localparam logic [1:0] POS_ON      = 2'd0;
   localparam logic [1:0] POS_OFF     = 2'd1;
   localparam logic [1:0] POS_END     = 2'd2;
   localparam logic [1:0] POS_STOPPED = 2'd3;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_RUN  = 1'b1;

   localparam logic [15:0] CALIB_ON_RESET  = 16'd50;
   localparam logic [15:0] CALIB_OFF_RESET = 16'd450;
   localparam logic [15:0] ALIVE_ON_RESET  = 16'd50;
   localparam logic [15:0] ALIVE_OFF_RESET = 16'd1950;
   localparam logic [15:0] LINK_ON_RESET   = 16'd1;
   localparam logic [15:0] LINK_OFF_RESET  = 16'd0;

   typedef struct packed {
      logic       operation;
      logic [2:0] led_index;
      logic [1:0] sequence_select;
   } req_word_type;

   typedef struct packed {
      logic [7:0] led_levels;
      logic [1:0] active_sequence;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]               active;
      logic [NUM_SEQ-1:0][1:0]  pos;
      logic [15:0]              count;
      logic                     running;
   } led_rec_type;

   localparam led_rec_type LED_REC_RESET = '{
      active:  SEQ_NONE,
      pos:     {NUM_SEQ{POS_STOPPED}},
      count:   16'd0,
      running: 1'b0
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_WALK,
      ST_WRITE
   } state_type;

   typedef enum logic [2:0] {
      REG_RUN_ENABLE,
      REG_CALIB_ON,
      REG_CALIB_OFF,
      REG_ALIVE_ON,
      REG_ALIVE_OFF,
      REG_LINK_ON,
      REG_LINK_OFF
   } csr_index_type;

endpackage

// ===== hdl/pls_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module pls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/priority_led_sequencer_core.sv =====
// Top level of the priority LED sequencer: control, state memory and registers.
//
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+-------------------------------
//  request  | start, busy, req_data                  | word taken when start && !busy
//  result   | rsp_valid, rsp_data                    | one-cycle strobe, no stall
//  register | psel penable pwrite paddr pwdata prdata | APB write in access cycle
//
// A run word passes through the load state, the walk state for each sequence step walked, and
// the write state; a tick word does the same for every LED, one memory read-modify-write per LED.
// The result strobe is high in the first cycle with busy low, and the receiver cannot stall
// it; a run on an absent LED answers in the next cycle without going busy. Reset is
// synchronous; valid bits make every LED read as stopped after reset, so no clearing pass
// is needed.
module priority_led_sequencer_core import pls_pkg::*; #(
   parameter int LED_COUNT = LED_COUNT_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   output rsp_word_type          rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int IDX_W   = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int CNT_W   = $clog2(LED_COUNT + 1);
   localparam int CMP_W   = (CNT_W > 3) ? CNT_W : 3;
   localparam int SHOWN   = (LED_COUNT < 8) ? LED_COUNT : 8;
   localparam int GUARD_W = $clog2(WALK_LIMIT);
   localparam int REC_W   = $bits(led_rec_type);
   localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(LED_COUNT - 1);
   localparam logic [GUARD_W-1:0] LAST_GUARD = GUARD_W'(WALK_LIMIT - 1);

   state_type state_ff, state_in;
   logic [LED_COUNT-1:0] valid_ff, valid_in;
   logic [LED_COUNT-1:0] lit_ff, lit_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_data_ff, rsp_data_in;
   logic run_en_ff, run_en_in;
   logic [NUM_SEQ-1:0][1:0][15:0] dur_ff, dur_in;

   led_rec_type w_ff, w_in;
   logic wlit_ff, wlit_in;
   logic [GUARD_W-1:0] guard_ff, guard_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic op_ff, op_in;
   logic [1:0] sel_ff, sel_in;
   logic [CMP_W-1:0] led_ff, led_in;
   logic [1:0] act_ff, act_in;

   logic ram_we;
   logic [IDX_W-1:0] rd_addr;
   logic [REC_W-1:0] ram_q;
   logic [CMP_W-1:0] req_led;
   logic csr_wr;

   function automatic logic [1:0] pick_seq(input logic [NUM_SEQ-1:0][1:0] pos_v);
      logic [1:0] r;
      r = SEQ_NONE;
      for (int s = NUM_SEQ - 1; s >= 0; s--) begin
         if (pos_v[s] != POS_STOPPED) begin
            r = 2'(s);
         end
      end
      return r;
   endfunction

   pls_ram #(
      .WIDTH (REC_W),
      .DEPTH (LED_COUNT)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data (REC_W'(w_ff)),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign req_led = CMP_W'(req_data.led_index);
   assign csr_wr  = psel && penable && pwrite;
   assign busy    = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;

   always_comb begin
      led_rec_type ld;
      led_rec_type wk;
      logic [1:0] p;
      logic [1:0] pos;
      logic [15:0] t;
      logic [15:0] cnt;
      logic lit;
      logic fin;

      state_in     = state_ff;
      valid_in     = valid_ff;
      lit_in       = lit_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      run_en_in    = run_en_ff;
      dur_in       = dur_ff;
      w_in         = w_ff;
      wlit_in      = wlit_ff;
      guard_in     = guard_ff;
      idx_in       = idx_ff;
      op_in        = op_ff;
      sel_in       = sel_ff;
      led_in       = led_ff;
      act_in       = act_ff;
      ram_we       = 1'b0;
      rd_addr      = idx_ff;

      ld  = valid_ff[idx_ff] ? led_rec_type'(ram_q) : LED_REC_RESET;
      wk  = w_ff;
      lit = wlit_ff;
      fin = 1'b0;
      p   = w_ff.active;
      pos = POS_ON;
      t   = 16'd0;
      cnt = 16'd0;

      if (csr_wr) begin
         unique case (paddr[CSR_ADDR_W-1:2])
            REG_RUN_ENABLE: run_en_in = pwdata[0];
            REG_CALIB_ON:   dur_in[SEQ_CALIB][0] = pwdata[15:0];
            REG_CALIB_OFF:  dur_in[SEQ_CALIB][1] = pwdata[15:0];
            REG_ALIVE_ON:   dur_in[SEQ_HEARTBEAT][0] = pwdata[15:0];
            REG_ALIVE_OFF:  dur_in[SEQ_HEARTBEAT][1] = pwdata[15:0];
            REG_LINK_ON:    dur_in[SEQ_LINK][0] = pwdata[15:0];
            REG_LINK_OFF:   dur_in[SEQ_LINK][1] = pwdata[15:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = (req_data.operation == OP_RUN) ? IDX_W'(req_led) : '0;
            if (start) begin
               op_in  = req_data.operation;
               sel_in = req_data.sequence_select;
               led_in = req_led;
               act_in = SEQ_NONE;
               if (req_data.operation == OP_RUN) begin
                  idx_in = IDX_W'(req_led);
                  if (req_led < CMP_W'(LED_COUNT)) begin
                     state_in = ST_LOAD;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in.led_levels = 8'(lit_ff[SHOWN-1:0]);
                     rsp_data_in.active_sequence = SEQ_NONE;
                  end
               end else begin
                  idx_in   = '0;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            wk  = ld;
            lit = lit_ff[idx_ff];
            state_in = ST_WRITE;
            if (op_ff == OP_RUN) begin
               if (sel_ff != SEQ_NONE) begin
                  wk.pos[sel_ff] = POS_ON;
                  wk.active = pick_seq(wk.pos);
                  lit = 1'b0;
                  if (run_en_ff && wk.active == sel_ff) begin
                     state_in = ST_WALK;
                  end
               end
            end else if (ld.running) begin
               cnt = (ld.count != 16'd0) ? ld.count - 16'd1 : ld.count;
               wk.count = cnt;
               if (cnt == 16'd0) begin
                  wk.running = 1'b0;
                  if (run_en_ff) begin
                     state_in = ST_WALK;
                  end
               end
            end
            w_in     = wk;
            wlit_in  = lit;
            guard_in = '0;
         end
         ST_WALK: begin
            if (p == SEQ_NONE) begin
               wk.running = 1'b0;
               fin = 1'b1;
            end else begin
               pos = w_ff.pos[p];
               if (pos == POS_STOPPED) begin
                  wk.active = pick_seq(w_ff.pos);
                  lit = 1'b0;
               end else if (pos != POS_END) begin
                  wk.pos[p] = pos + 2'd1;
                  t = dur_ff[p][pos[0]];
                  lit = (pos == POS_ON);
                  if (t != 16'd0) begin
                     wk.count   = t;
                     wk.running = 1'b1;
                     fin = 1'b1;
                  end
               end else if (p == SEQ_LINK) begin
                  wk.pos[p] = POS_STOPPED;
                  wk.active = pick_seq(wk.pos);
                  lit = 1'b0;
               end else begin
                  wk.pos[p] = POS_ON;
                  if (dur_ff[p][0] == 16'd0 && dur_ff[p][1] == 16'd0) begin
                     wk.count   = 16'd1;
                     wk.running = 1'b1;
                     fin = 1'b1;
                  end
               end
            end
            if (!fin && guard_ff == LAST_GUARD) begin
               wk.count   = 16'd1;
               wk.running = 1'b1;
               fin = 1'b1;
            end
            w_in     = wk;
            wlit_in  = lit;
            guard_in = guard_ff + 1'b1;
            if (fin) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            ram_we = 1'b1;
            valid_in[idx_ff] = 1'b1;
            lit_in[idx_ff]   = wlit_ff;
            if (led_ff == CMP_W'(idx_ff)) begin
               act_in = w_ff.active;
            end
            if (op_ff == OP_TICK && idx_ff != LAST_IDX) begin
               idx_in   = idx_ff + 1'b1;
               rd_addr  = idx_ff + 1'b1;
               state_in = ST_LOAD;
            end else begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in.led_levels      = 8'(lit_in[SHOWN-1:0]);
               rsp_data_in.active_sequence = act_in;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      unique case (paddr[CSR_ADDR_W-1:2])
         REG_RUN_ENABLE: prdata = {31'd0, run_en_ff};
         REG_CALIB_ON:   prdata = 32'(dur_ff[SEQ_CALIB][0]);
         REG_CALIB_OFF:  prdata = 32'(dur_ff[SEQ_CALIB][1]);
         REG_ALIVE_ON:   prdata = 32'(dur_ff[SEQ_HEARTBEAT][0]);
         REG_ALIVE_OFF:  prdata = 32'(dur_ff[SEQ_HEARTBEAT][1]);
         REG_LINK_ON:    prdata = 32'(dur_ff[SEQ_LINK][0]);
         REG_LINK_OFF:   prdata = 32'(dur_ff[SEQ_LINK][1]);
         default:        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         lit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         run_en_ff    <= 1'b1;
         dur_ff[SEQ_CALIB][0]     <= CALIB_ON_RESET;
         dur_ff[SEQ_CALIB][1]     <= CALIB_OFF_RESET;
         dur_ff[SEQ_HEARTBEAT][0] <= ALIVE_ON_RESET;
         dur_ff[SEQ_HEARTBEAT][1] <= ALIVE_OFF_RESET;
         dur_ff[SEQ_LINK][0]      <= LINK_ON_RESET;
         dur_ff[SEQ_LINK][1]      <= LINK_OFF_RESET;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         lit_ff       <= lit_in;
         rsp_valid_ff <= rsp_valid_in;
         run_en_ff    <= run_en_in;
         dur_ff       <= dur_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      w_ff        <= w_in;
      wlit_ff     <= wlit_in;
      guard_ff    <= guard_in;
      idx_ff      <= idx_in;
      op_ff       <= op_in;
      sel_ff      <= sel_in;
      led_ff      <= led_in;
      act_ff      <= act_in;
   end

endmodule

// ===== hdl/pls_checker.sv =====
// Port-level checker of the priority LED sequencer and its bind to the top level.
module pls_checker import pls_pkg::*; #(
   parameter int LED_COUNT = LED_COUNT_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input req_word_type req_data,
   input logic         rsp_valid,
   input rsp_word_type rsp_data
);

   logic accepted;
   logic absent_run;

   assign accepted   = start && !busy;
   assign absent_run = (req_data.operation == OP_RUN) &&
                       (32'(req_data.led_index) >= 32'(LED_COUNT));

   assert property (@(posedge clock) disable iff (reset)
      accepted && !absent_run |=> busy)
      else $error("Accepted word did not make the block busy.");

   assert property (@(posedge clock) disable iff (reset)
      accepted && absent_run |=> rsp_valid && rsp_data.active_sequence == SEQ_NONE)
      else $error("Run on an absent LED did not answer at once with no sequence.");

   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("Block went idle without a result.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("Result shown while the block is busy.");

endmodule

bind priority_led_sequencer_core pls_checker #(.LED_COUNT(LED_COUNT)) u_pls_checker (.*);
